### hdl/sss_pkg.sv
// Shared types, sizes and codes for the scoped symbol stack.
package sss_pkg;

    // Table geometry
    localparam int ENTRIES  = 256;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int KEY_BITS = 64;
    localparam int DEPTH_W  = 8;
    localparam int MAX_NEST = 255;

    // Field widths of the beats
    localparam int OP_W     = 4;
    localparam int STATUS_W = 2;
    localparam int TYPE_W   = 8;
    localparam int SLOT_W   = 8;
    localparam int SCNT_W   = 9;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD        = 4'd0;
    localparam logic [OP_W-1:0] OP_ADD_SIZED  = 4'd1;
    localparam logic [OP_W-1:0] OP_ENTER      = 4'd2;
    localparam logic [OP_W-1:0] OP_ENTER_FUNC = 4'd3;
    localparam logic [OP_W-1:0] OP_EXIT       = 4'd4;
    localparam logic [OP_W-1:0] OP_LOOKUP     = 4'd5;
    localparam logic [OP_W-1:0] OP_READ       = 4'd6;
    localparam logic [OP_W-1:0] OP_POP        = 4'd7;
    localparam logic [OP_W-1:0] OP_PEEK       = 4'd8;
    localparam logic [OP_W-1:0] OP_CLEAR      = 4'd9;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [63:0]         name_key;
        logic [TYPE_W-1:0]   sym_type;
        logic [SCNT_W-1:0]   slot_count;
        logic [SLOT_W-1:0]   slot_index;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   result_slot;
        logic [63:0]         out_name;
        logic [TYPE_W-1:0]   out_type;
    } result_t;

    // One stored table entry
    typedef struct packed {
        logic [KEY_BITS-1:0] name;
        logic [TYPE_W-1:0]   sym_type;
        logic [DEPTH_W-1:0]  scope;
    } entry_t;

    // Compare unit verdict
    typedef struct packed {
        logic hit;
        logic drop;
    } match_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FILL,
        S_LOOKUP,
        S_EXIT,
        S_READ_WAIT,
        S_FINISH
    } state_t;

endpackage

### hdl/sss_ram.sv
// Simple dual-port RAM with one write port and a registered read port.
module sss_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 80
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read word
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### hdl/sss_match.sv
// Shared compare unit: name match, visibility and scope-drop test of one entry.
module sss_match
    import sss_pkg::*;
(
    input  logic [KEY_BITS-1:0] key,
    input  entry_t              entry,
    input  logic [DEPTH_W-1:0]  cur_depth,
    input  logic [DEPTH_W-1:0]  fn_depth,
    output match_t              verdict
);

    logic visible;

    // Visible when inside the current function or at global depth
    always_comb
    begin
        visible      = (entry.scope >= fn_depth) || (entry.scope == '0);
        verdict.hit  = (entry.name == key) && visible;
        verdict.drop = entry.scope > cur_depth;
    end

endmodule

### hdl/scoped_symbol_stack.sv
// Top level of the scoped symbol stack: sequencer, state registers and result register.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_ready  item_t   (op, key, type, count, index)
//   rsp       out        rsp_valid / rsp_ready  result_t (status, slot, name, type)
//
// One beat is taken at a time; req_ready is high only while the sequencer is idle.
// Simple ops, a full add and an out-of-range read go straight to finish. Add writes one RAM
// slot a cycle; lookup scans up from slot 0 and scope exit down from the top, one entry a
// cycle through the RAM read port and the shared compare unit. Read, peek and pop of a present
// entry wait on the registered read. Reset clears state, counters, depths and valid flags only.
// A stalled rsp holds its beat; the next result waits in the sequencer until it drains.
module scoped_symbol_stack
    import sss_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    input  item_t   req,
    output logic    rsp_valid,
    input  logic    rsp_ready,
    output result_t rsp
);

    state_t             state_reg, state_next;
    item_t              item_reg, item_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [DEPTH_W-1:0] cur_depth_reg, cur_depth_next;
    logic [DEPTH_W-1:0] fn_depth_reg, fn_depth_next;
    logic [CNT_W-1:0]   fill_left_reg, fill_left_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic               chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]   chk_addr_reg, chk_addr_next;
    result_t            res_reg, res_next;
    logic               rsp_valid_reg, rsp_valid_next;
    result_t            rsp_reg, rsp_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   rd_addr;
    entry_t             wr_entry;
    entry_t             rd_entry;
    logic [$bits(entry_t)-1:0] rd_word;
    match_t             verdict;

    logic [CNT_W-1:0]   add_cnt;
    logic [CNT_W-1:0]   space;
    logic               add_full;
    logic               rd_ok;
    logic               lk_hit;
    logic               lk_end;
    logic               ex_end;
    logic               out_free;
    logic [CNT_W-1:0]   used_dec;
    logic [DEPTH_W-1:0] depth_up;

    // Entry storage
    sss_ram #(
        .DEPTH(ENTRIES),
        .WIDTH($bits(entry_t))
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    assign rd_entry = entry_t'(rd_word);

    // Compare the entry just read
    sss_match u_match (
        .key       (item_reg.name_key[KEY_BITS-1:0]),
        .entry     (rd_entry),
        .cur_depth (cur_depth_reg),
        .fn_depth  (fn_depth_reg),
        .verdict   (verdict)
    );

    // Shared conditions
    always_comb
    begin
        if ((item_reg.op == OP_ADD) || (item_reg.slot_count == '0))
        begin
            add_cnt = CNT_W'(1);
        end
        else
        begin
            add_cnt = CNT_W'(item_reg.slot_count);
        end
        space    = CNT_W'(ENTRIES) - used_reg;
        add_full = add_cnt > space;
        rd_ok    = CNT_W'(item_reg.slot_index) < used_reg;
        lk_hit   = chk_vld_reg && verdict.hit;
        lk_end   = lk_hit || (scan_reg >= used_reg);
        ex_end   = (chk_vld_reg && !verdict.drop) || (!chk_vld_reg && (scan_reg == '0));
        out_free = !rsp_valid_reg || rsp_ready;
        used_dec = used_reg - CNT_W'(1);
        depth_up = (cur_depth_reg < DEPTH_W'(MAX_NEST)) ? cur_depth_reg + DEPTH_W'(1)
                                                         : cur_depth_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if ((item_reg.op == OP_ADD) || (item_reg.op == OP_ADD_SIZED))
                begin
                    state_next = add_full ? S_FINISH : S_FILL;
                end
                else if (item_reg.op == OP_LOOKUP)
                begin
                    state_next = S_LOOKUP;
                end
                else if (item_reg.op == OP_EXIT)
                begin
                    state_next = S_EXIT;
                end
                else if (item_reg.op == OP_READ)
                begin
                    state_next = rd_ok ? S_READ_WAIT : S_FINISH;
                end
                else if ((item_reg.op == OP_POP) || (item_reg.op == OP_PEEK))
                begin
                    state_next = (used_reg != '0) ? S_READ_WAIT : S_FINISH;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FILL:
            begin
                if (fill_left_reg == CNT_W'(1))
                begin
                    state_next = S_FINISH;
                end
            end
            S_LOOKUP:
            begin
                if (lk_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_EXIT:
            begin
                if (ex_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_READ_WAIT:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        item_next      = item_reg;
        used_next      = used_reg;
        cur_depth_next = cur_depth_reg;
        fn_depth_next  = fn_depth_reg;
        fill_left_next = fill_left_reg;
        scan_next      = scan_reg;
        chk_vld_next   = 1'b0;
        chk_addr_next  = chk_addr_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        wr_en          = 1'b0;
        wr_addr        = used_reg[IDX_W-1:0];
        wr_entry.name     = item_reg.name_key[KEY_BITS-1:0];
        wr_entry.sym_type = item_reg.sym_type;
        wr_entry.scope    = cur_depth_reg;
        rd_addr        = '0;
        req_ready      = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                // Take the next beat
                if (req_valid)
                begin
                    item_next = req;
                end
            end
            S_DECODE:
            begin
                res_next = '0;
                priority if ((item_reg.op == OP_ADD) || (item_reg.op == OP_ADD_SIZED))
                begin
                    if (add_full)
                    begin
                        res_next.status = ST_FULL;
                    end
                    else
                    begin
                        res_next.result_slot = used_reg[SLOT_W-1:0];
                        fill_left_next       = add_cnt;
                    end
                end
                else if (item_reg.op == OP_ENTER)
                begin
                    cur_depth_next = depth_up;
                end
                else if (item_reg.op == OP_ENTER_FUNC)
                begin
                    cur_depth_next = depth_up;
                    fn_depth_next  = depth_up;
                end
                else if (item_reg.op == OP_EXIT)
                begin
                    // Lower the depth, then scan down from the top
                    if (cur_depth_reg != '0)
                    begin
                        cur_depth_next = cur_depth_reg - DEPTH_W'(1);
                    end
                    scan_next = used_reg;
                end
                else if (item_reg.op == OP_LOOKUP)
                begin
                    res_next.status = ST_NOT_FOUND;
                    scan_next       = '0;
                end
                else if (item_reg.op == OP_READ)
                begin
                    if (rd_ok)
                    begin
                        rd_addr              = item_reg.slot_index[IDX_W-1:0];
                        res_next.result_slot = item_reg.slot_index;
                    end
                    else
                    begin
                        res_next.status = ST_NOT_FOUND;
                    end
                end
                else if ((item_reg.op == OP_POP) || (item_reg.op == OP_PEEK))
                begin
                    if (used_reg == '0)
                    begin
                        res_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        rd_addr              = used_dec[IDX_W-1:0];
                        res_next.result_slot = used_dec[SLOT_W-1:0];
                        if (item_reg.op == OP_POP)
                        begin
                            used_next = used_dec;
                        end
                    end
                end
                else if (item_reg.op == OP_CLEAR)
                begin
                    used_next      = '0;
                    cur_depth_next = '0;
                end
                else
                begin
                    res_next = '0;
                end
            end
            S_FILL:
            begin
                // Write one reserved slot a cycle
                wr_en          = 1'b1;
                used_next      = used_reg + CNT_W'(1);
                fill_left_next = fill_left_reg - CNT_W'(1);
            end
            S_LOOKUP:
            begin
                // Check the entry read last cycle, issue the next read
                if (lk_hit)
                begin
                    res_next.status      = ST_OK;
                    res_next.result_slot = SLOT_W'(chk_addr_reg);
                    res_next.out_name    = 64'(rd_entry.name);
                    res_next.out_type    = rd_entry.sym_type;
                end
                else if (scan_reg < used_reg)
                begin
                    rd_addr       = scan_reg[IDX_W-1:0];
                    scan_next     = scan_reg + CNT_W'(1);
                    chk_vld_next  = 1'b1;
                    chk_addr_next = scan_reg[IDX_W-1:0];
                end
            end
            S_EXIT:
            begin
                // Drop deeper entries from the top, one a cycle
                if (chk_vld_reg && verdict.drop)
                begin
                    used_next = CNT_W'(chk_addr_reg);
                end
                if ((scan_reg != '0) && !(chk_vld_reg && !verdict.drop))
                begin
                    rd_addr       = IDX_W'(scan_reg - CNT_W'(1));
                    scan_next     = scan_reg - CNT_W'(1);
                    chk_vld_next  = 1'b1;
                    chk_addr_next = IDX_W'(scan_reg - CNT_W'(1));
                end
            end
            S_READ_WAIT:
            begin
                res_next.out_name = 64'(rd_entry.name);
                res_next.out_type = rd_entry.sym_type;
            end
            S_FINISH:
            begin
                // Hand the result to the output register once it is free
                if (out_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            cur_depth_reg <= '0;
            fn_depth_reg  <= '0;
            chk_vld_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            cur_depth_reg <= cur_depth_next;
            fn_depth_reg  <= fn_depth_next;
            chk_vld_reg   <= chk_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        fill_left_reg <= fill_left_next;
        scan_reg      <= scan_next;
        chk_addr_reg  <= chk_addr_next;
        res_reg       <= res_next;
        rsp_reg       <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(ENTRIES))
        else $error("used slot count beyond table size");

    a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> (fill_left_reg != '0))
        else $error("fill running with nothing left to write");

    a_exit_top: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EXIT) && chk_vld_reg) |-> (CNT_W'(chk_addr_reg) + CNT_W'(1) == used_reg))
        else $error("scope exit checks an entry other than the top");

    a_lookup_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOKUP) |-> (scan_reg <= used_reg))
        else $error("lookup scan ran past the used slots");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_DECODE))
        else $error("accepted beat not decoded next cycle");
`endif

endmodule

### tb/tb_scoped_symbol_stack.sv
// Self-checking testbench for the scoped symbol stack: directed cases plus random traffic.
module tb_scoped_symbol_stack
    import sss_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // Timeout limit, set well above the slowest correct run
    localparam int CYCLE_LIMIT = 2_000_000;
    // Longest single op: add sized of a full table or a full-table scan
    localparam int DRAIN_CYCLES = 300;

    localparam logic [63:0] KEY_COUNT = "count";
    localparam logic [63:0] KEY_INDEX = "index";
    localparam logic [63:0] KEY_BUF   = "buf";
    localparam logic [63:0] KEY_ARRAY = "array";

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    req_valid = 1'b0;
    logic    req_ready;
    item_t   req = '0;
    logic    rsp_valid;
    logic    rsp_ready = 1'b0;
    result_t rsp;

    // Shadow copy of the symbol table
    logic [63:0]        tbl_name  [ENTRIES];
    logic [TYPE_W-1:0]  tbl_kind  [ENTRIES];
    logic [DEPTH_W-1:0] tbl_scope [ENTRIES];
    int                 used_cnt = 0;
    int                 scope_depth = 0;
    int                 func_depth = 0;
    int                 peak_fill = 0;
    int                 peak_depth = 0;

    result_t     pending_results[$];
    logic [63:0] key_pool[16];

    int items_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int cycle_count = 0;
    int gap_max = 0;
    int burst_left = 0;
    int stall_tick = 0;
    int stall_mode = 0;

    scoped_symbol_stack uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, pending_results.size());
            $display("tb_scoped_symbol_stack: errors");
            $finish;
        end
    end

    // Receiver: periodically switch among four stall patterns
    always @(posedge clk)
    begin
        stall_tick++;
        if (stall_tick % 256 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ready <= (stall_tick % 3 == 0);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Compare each result beat against the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            results_seen++;
            status_seen[rsp.status]++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat %0d with nothing expected: %h", results_seen, rsp);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.status !== want.status || rsp.result_slot !== want.result_slot ||
                    rsp.out_name !== want.out_name || rsp.out_type !== want.out_type)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $write("mismatch at result %0d: status %0d/%0d slot %0d/%0d ",
                               results_seen, want.status, rsp.status,
                               want.result_slot, rsp.result_slot);
                        $display("name %h/%h type %h/%h (expected/actual)",
                                 want.out_name, rsp.out_name, want.out_type, rsp.out_type);
                    end
                end
            end
        end
    end

    function automatic result_t entry_result(input int slot);
        result_t r;
        r.status      = ST_OK;
        r.result_slot = SLOT_W'(slot);
        r.out_name    = tbl_name[slot];
        r.out_type    = tbl_kind[slot];
        return r;
    endfunction

    // Apply one operation to the shadow table and return the expected result
    function automatic result_t apply_symbol_op(input item_t it);
        result_t     r;
        logic [63:0] key;
        int          cnt;
        int          i;
        bit          found;
        r     = '0;
        key   = it.name_key & ({64{1'b1}} >> (64 - KEY_BITS));
        found = 1'b0;
        case (it.op)
            OP_ADD, OP_ADD_SIZED:
            begin
                cnt = (it.op == OP_ADD || it.slot_count == 0) ? 1 : int'(it.slot_count);
                if (cnt > ENTRIES - used_cnt)
                    r.status = ST_FULL;
                else
                begin
                    for (i = 0; i < cnt; i++)
                    begin
                        tbl_name[used_cnt + i]  = key;
                        tbl_kind[used_cnt + i]  = it.sym_type;
                        tbl_scope[used_cnt + i] = DEPTH_W'(scope_depth);
                    end
                    r.result_slot = SLOT_W'(used_cnt);
                    used_cnt += cnt;
                end
            end
            OP_ENTER:
            begin
                if (scope_depth < MAX_NEST)
                    scope_depth++;
            end
            OP_ENTER_FUNC:
            begin
                if (scope_depth < MAX_NEST)
                    scope_depth++;
                func_depth = scope_depth;
            end
            OP_EXIT:
            begin
                if (scope_depth > 0)
                    scope_depth--;
                while (used_cnt > 0 && int'(tbl_scope[used_cnt - 1]) > scope_depth)
                    used_cnt--;
            end
            OP_LOOKUP:
            begin
                r.status = ST_NOT_FOUND;
                for (i = 0; i < used_cnt; i++)
                begin
                    if (!found && tbl_name[i] == key &&
                        (int'(tbl_scope[i]) >= func_depth || tbl_scope[i] == 0))
                    begin
                        r     = entry_result(i);
                        found = 1'b1;
                    end
                end
            end
            OP_READ:
            begin
                if (int'(it.slot_index) < used_cnt)
                    r = entry_result(int'(it.slot_index));
                else
                    r.status = ST_NOT_FOUND;
            end
            OP_POP, OP_PEEK:
            begin
                if (used_cnt == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r = entry_result(used_cnt - 1);
                    if (it.op == OP_POP)
                        used_cnt--;
                end
            end
            OP_CLEAR:
            begin
                used_cnt    = 0;
                scope_depth = 0;
            end
            default: ;
        endcase
        if (used_cnt > peak_fill)
            peak_fill = used_cnt;
        if (scope_depth > peak_depth)
            peak_depth = scope_depth;
        return r;
    endfunction

    // Drive one request beat, record its prediction on acceptance, then maybe idle
    task automatic send_item(input item_t it);
        req       <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pending_results.push_back(apply_symbol_op(it));
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 15);
            if (gap_max > 0)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            end
        end
    endtask

    function automatic item_t make_item(input logic [OP_W-1:0] op, input logic [63:0] key,
                                        input logic [TYPE_W-1:0] kind,
                                        input logic [SCNT_W-1:0] cnt,
                                        input logic [SLOT_W-1:0] idx);
        item_t it;
        it.op         = op;
        it.name_key   = key;
        it.sym_type   = kind;
        it.slot_count = cnt;
        it.slot_index = idx;
        return it;
    endfunction

    // Mostly pool keys so lookups hit; sometimes fully random names
    function automatic logic [63:0] pick_key();
        if ($urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, 15)];
        return {$urandom, $urandom};
    endfunction

    // Mostly small reservations, a few large or oversized
    function automatic logic [SCNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return SCNT_W'($urandom_range(0, 511));
        if (r < 10)
            return SCNT_W'($urandom_range(9, 64));
        return SCNT_W'($urandom_range(0, 8));
    endfunction

    function automatic logic [SLOT_W-1:0] pick_index();
        if (used_cnt > 0 && $urandom_range(0, 4) != 0)
            return SLOT_W'($urandom_range(0, used_cnt - 1));
        return SLOT_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [OP_W-1:0] random_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return OP_ADD;
        if (r < 30) return OP_ADD_SIZED;
        if (r < 40) return OP_ENTER;
        if (r < 47) return OP_ENTER_FUNC;
        if (r < 58) return OP_EXIT;
        if (r < 76) return OP_LOOKUP;
        if (r < 84) return OP_READ;
        if (r < 89) return OP_POP;
        if (r < 93) return OP_PEEK;
        if (r < 95) return OP_CLEAR;
        return OP_W'($urandom_range(10, 15));
    endfunction

    // Send one op with random content in every field
    task automatic send_op(input logic [OP_W-1:0] op);
        send_item(make_item(op, pick_key(), TYPE_W'($urandom), pick_count(), pick_index()));
    endtask

    // Pop, peek, read and lookup on an empty table
    task automatic test_empty_table();
        send_item(make_item(OP_PEEK, '0, '0, '0, '0));
        send_item(make_item(OP_POP, '0, '0, '0, '0));
        send_item(make_item(OP_READ, '0, '0, '0, '0));
        send_item(make_item(OP_LOOKUP, '1, '1, '1, '1));
    endtask

    // Scopes, function boundary visibility, add sized footprint, exit drop
    task automatic test_scopes_and_lookup();
        send_item(make_item(OP_ADD, '0, '0, '0, '0));
        send_item(make_item(OP_ADD, '1, '1, '1, '1));
        send_item(make_item(OP_ENTER, '0, '0, '0, '0));
        send_item(make_item(OP_ADD, KEY_COUNT, 8'h5a, '0, '0));
        send_item(make_item(OP_ENTER_FUNC, '0, '0, '0, '0));
        // declared one scope outside the function: hidden
        send_item(make_item(OP_LOOKUP, KEY_COUNT, '0, '0, '0));
        // global scope stays visible
        send_item(make_item(OP_LOOKUP, '1, '0, '0, '0));
        send_item(make_item(OP_ADD_SIZED, KEY_INDEX, 8'h11, 9'd0, '0));
        send_item(make_item(OP_ADD_SIZED, KEY_BUF, 8'ha5, 9'd3, '0));
        send_item(make_item(OP_LOOKUP, KEY_BUF, '0, '0, '0));
        send_item(make_item(OP_READ, '0, '0, '0, 8'd5));
        send_item(make_item(OP_READ, '0, '0, '0, 8'd7));
        send_item(make_item(OP_EXIT, '0, '0, '0, '0));
        send_item(make_item(OP_PEEK, '0, '0, '0, '0));
        send_item(make_item(OP_POP, '0, '0, '0, '0));
        send_item(make_item(4'd15, '1, '1, '1, '1));
        send_item(make_item(OP_CLEAR, '0, '0, '0, '0));
        // exit with depth already zero
        send_item(make_item(OP_EXIT, '0, '0, '0, '0));
    endtask

    // Fill the whole table, then hit full, top slot and oversized reservations
    task automatic test_capacity();
        send_item(make_item(OP_ADD_SIZED, KEY_ARRAY, 8'h3c, 9'd256, '0));
        send_item(make_item(OP_ADD, KEY_COUNT, 8'h01, '0, '0));
        send_item(make_item(OP_READ, '0, '0, '0, 8'd255));
        send_item(make_item(OP_POP, '0, '0, '0, '0));
        send_item(make_item(OP_ADD_SIZED, KEY_BUF, 8'h02, 9'd2, '0));
        send_item(make_item(OP_ADD_SIZED, KEY_BUF, 8'h03, 9'd511, '0));
        send_item(make_item(OP_CLEAR, '0, '0, '0, '0));
    endtask

    // Nest until the depth saturates, then unwind one exit at a time
    task automatic test_deep_nesting();
        int extra;
        int r;
        extra = 0;
        send_op(OP_CLEAR);
        while (extra < 8)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
                send_op(OP_ENTER);
            else if (r < 82)
                send_op(OP_ENTER_FUNC);
            else if (r < 94)
                send_op(OP_ADD);
            else
                send_op(OP_LOOKUP);
            if (scope_depth == MAX_NEST)
                extra++;
        end
        while (scope_depth > 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 85)
                send_op(OP_EXIT);
            else if (r < 95)
                send_op(OP_LOOKUP);
            else
                send_op(OP_PEEK);
        end
    endtask

    // Well-formed function bodies with random content, some left open or broken
    task automatic test_function_bodies(input int count);
        int stop_at;
        int n;
        int k;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            send_op(OP_ENTER_FUNC);
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++)
                send_op(($urandom_range(0, 3) == 0) ? OP_ADD_SIZED : OP_ADD);
            if ($urandom_range(0, 1) != 0)
            begin
                send_op(OP_ENTER);
                send_op(OP_ADD);
                send_op(OP_LOOKUP);
                send_op(OP_EXIT);
            end
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++)
                send_op(OP_LOOKUP);
            if ($urandom_range(0, 2) == 0)
                send_op(OP_READ);
            if ($urandom_range(0, 9) == 0)
                send_op(random_op());
            if ($urandom_range(0, 7) != 0)
                send_op(OP_EXIT);
            if (used_cnt > 200)
                send_op(OP_CLEAR);
        end
    endtask

    // Weighted mix of every op
    task automatic test_random_mix(input int count);
        int k;
        for (k = 0; k < count; k++)
            send_op(random_op());
    endtask

    initial
    begin
        int k;
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = KEY_COUNT;
        key_pool[3] = KEY_INDEX;
        for (k = 4; k < 16; k++)
            key_pool[k] = {$urandom, $urandom};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_max = 4;
        test_empty_table();
        test_scopes_and_lookup();
        test_capacity();

        gap_max = 0;
        test_deep_nesting();
        gap_max = 6;
        test_function_bodies(300);
        gap_max = 0;
        test_random_mix(300);
        gap_max = 8;
        test_random_mix(300);
        req_valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d ops, %0d results: ok %0d, full %0d, not found %0d, empty %0d",
                 items_sent, results_seen, status_seen[0], status_seen[1],
                 status_seen[2], status_seen[3]);
        $display("peak table fill %0d of %0d, peak scope depth %0d, %0d mismatches",
                 peak_fill, ENTRIES, peak_depth, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_scoped_symbol_stack: clean");
        else
            $display("tb_scoped_symbol_stack: errors");
        $finish;
    end

endmodule
